FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the sieve RTL.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sieve assertion failed");

`define PPS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `PPS_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define PPS_ASSERT(lbl, clk, rst_n, prop)
`define PPS_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: rtl/core/pps_pkg.sv
// Shared constants and the serial slot type of the prime sieve.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int MAX_PRIMES  = 64;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    // One bit of a word on its way down the chain, MSB first.
    // hit and stored are meaningful on the last slot of a word.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic restart;
        logic dbit;
        logic hit;
        logic stored;
    } slot_t;

endpackage

`default_nettype wire

FILE: rtl/core/pps_in_if.sv
// Candidate channel: valid/ready handshake with candidate and restart.
// Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pps_in_if import pps_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] candidate;
    logic                   restart;

    modport source (output valid, candidate, restart, input ready);
    modport sink   (input valid, candidate, restart, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pps_out_if.sv
// Result channel: valid/ready handshake with prime and not_stored.
// Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pps_out_if import pps_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] prime;
    logic                   not_stored;

    modport source (output valid, prime, not_stored, input ready);
    modport sink   (input valid, prime, not_stored, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pps_feed.sv
// Serialiser: takes a candidate word and sends it MSB first into the chain.
// Depends on pps_pkg and pps_in_if.
`timescale 1ns / 1ps
`default_nettype none

module pps_feed import pps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    pps_in_if.sink    cand,
    output slot_t     head
);

    logic                   busy_reg, busy_next;
    logic [VALUE_WIDTH-1:0] sh_reg, sh_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   restart_reg, restart_next;
    logic                   hit_reg, hit_next;
    logic                   last_bit;
    logic                   acc;

    assign last_bit   = (cnt_reg == CNT_W'(VALUE_WIDTH - 1));
    assign cand.ready = !busy_reg || (en && last_bit);
    assign acc        = cand.valid && cand.ready;

    always_comb
    begin
        head.valid   = busy_reg;
        head.first   = (cnt_reg == '0);
        head.last    = last_bit;
        head.restart = restart_reg;
        head.dbit    = sh_reg[VALUE_WIDTH-1];
        head.hit     = hit_reg;
        head.stored  = 1'b0;
    end

    always_comb
    begin
        busy_next    = busy_reg;
        sh_next      = sh_reg;
        cnt_next     = cnt_reg;
        restart_next = restart_reg;
        hit_next     = hit_reg;
        if (acc)
        begin
            busy_next    = 1'b1;
            sh_next      = cand.candidate;
            cnt_next     = '0;
            restart_next = cand.restart;
            // 0 and 1 travel as already struck out
            hit_next     = (cand.candidate < VALUE_WIDTH'(2));
        end
        else if (en && busy_reg)
        begin
            sh_next  = {sh_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = last_bit ? '0 : cnt_reg + CNT_W'(1);
            if (last_bit)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg      <= sh_next;
        restart_reg <= restart_next;
        hit_reg     <= hit_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/pps_cell.sv
// One sieve cell: holds one prime, forms the running remainder bit-serially.
// An empty cell captures the first word that reaches it unstruck. Uses pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_cell import pps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire slot_t din,
    output slot_t      dout
);

    logic                   valid_reg, valid_next;
    logic [VALUE_WIDTH-1:0] prime_reg, prime_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    slot_t                  dout_reg, dout_next;

    logic                   valid_eff;
    logic [VALUE_WIDTH:0]   part;
    logic [VALUE_WIDTH:0]   diff;
    logic                   self_hit;
    logic                   store;

    assign dout = dout_reg;

    always_comb
    begin
        valid_eff = valid_reg && !(din.valid && din.first && din.restart);
        part      = {(din.first ? {VALUE_WIDTH{1'b0}} : rem_reg), din.dbit};
        diff      = part - {1'b0, prime_reg};
        rem_next  = (part >= {1'b0, prime_reg}) ? diff[VALUE_WIDTH-1:0]
                                                 : part[VALUE_WIDTH-1:0];
        self_hit  = valid_eff && (rem_next == '0);
        store     = din.valid && din.last && !valid_eff && !din.hit && !din.stored;
    end

    always_comb
    begin
        valid_next = valid_reg;
        prime_next = prime_reg;
        dout_next  = din;
        if (din.valid)
        begin
            valid_next = valid_eff || store;
            if (!valid_eff)
            begin
                prime_next = {prime_reg[VALUE_WIDTH-2:0], din.dbit};
            end
            dout_next.hit    = din.hit || (din.last && self_hit);
            dout_next.stored = din.stored || store;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dout_reg  <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
            dout_reg  <= dout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prime_reg <= prime_next;
            if (din.valid)
            begin
                rem_reg <= rem_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pipelined_prime_sieve_filter.sv
// Pipelined prime sieve: top level with feed, cell chain and output register.
// Depends on pps_pkg, pps_in_if, pps_out_if, pps_feed, pps_cell, assert_macros.svh.
//
// Usage:
//   cand (sink): candidate words, ascending from 2; restart set on a word
//   empties the stored primes before that word is tested.
//   res (source): one word per candidate >= 2 that no stored prime divides;
//   not_stored is set when every cell was already full.
//   Each candidate is shifted MSB first through a row of MAX_PRIMES cells,
//   one bit per cycle per cell while the output is not stalled; the feed
//   takes a new candidate when idle or as the last bit of the previous one
//   is sent. Several candidates are in the chain at once.
//   Reset empties all cells and drops words in flight.
//   While a result waits in the output register and res.ready is low, the
//   chain and feed shift nothing, though an idle feed may take a word; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pipelined_prime_sieve_filter import pps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pps_in_if.sink    cand,
    pps_out_if.source res
);

    slot_t                  chain [MAX_PRIMES+1];
    slot_t                  tail;
    logic                   en;
    logic                   load;

    logic [VALUE_WIDTH-1:0] asm_reg, asm_next;
    logic [VALUE_WIDTH-1:0] prime_reg, prime_next;
    logic                   ns_reg, ns_next;
    logic                   ovalid_reg, ovalid_next;

    assign en   = !(ovalid_reg && !res.ready);
    assign tail = chain[MAX_PRIMES];
    assign load = en && tail.valid && tail.last && !tail.hit;

    pps_feed u_feed (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cand  (cand),
        .head  (chain[0])
    );

    for (genvar i = 0; i < MAX_PRIMES; i++)
    begin : g_cell
        pps_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    always_comb
    begin
        asm_next    = asm_reg;
        prime_next  = prime_reg;
        ns_next     = ns_reg;
        ovalid_next = ovalid_reg && !res.ready;
        if (en && tail.valid)
        begin
            asm_next = {asm_reg[VALUE_WIDTH-2:0], tail.dbit};
        end
        if (load)
        begin
            prime_next  = {asm_reg[VALUE_WIDTH-2:0], tail.dbit};
            ns_next     = !tail.stored;
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asm_reg   <= asm_next;
        prime_reg <= prime_next;
        ns_reg    <= ns_next;
    end

    assign res.valid      = ovalid_reg;
    assign res.prime      = prime_reg;
    assign res.not_stored = ns_reg;

    `PPS_ASSERT(a_accept_starts_word, clk, rst_n,
        (cand.valid && cand.ready) |=> (chain[0].valid && chain[0].first))
    `PPS_ASSERT_NEVER(a_no_accept_mid_word, clk, rst_n,
        chain[0].valid && !chain[0].last && cand.ready)
    `PPS_ASSERT(a_result_from_tail, clk, rst_n,
        $rose(res.valid) |-> $past(tail.valid && tail.last && !tail.hit))

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for pipelined_prime_sieve_filter: drives candidate words,
// predicts the primes found and checks every result word as it leaves the block.
// Depends on pps_pkg, pps_in_if, pps_out_if and the sieve RTL.
`timescale 1ns / 1ps

module tb;
    import pps_pkg::*;

    localparam int ITEM_TARGET     = 950;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int TAIL_CYCLES     = 120;

    typedef struct {
        logic [VALUE_WIDTH-1:0] candidate;
        logic                   restart;
    } cand_word_t;

    typedef struct {
        logic [VALUE_WIDTH-1:0] prime;
        logic                   not_stored;
    } prime_word_t;

    typedef enum {PH_STEADY, PH_SEND_GAPS, PH_SINK_STALLS, PH_BOTH, PH_DRAIN} phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    pps_in_if  cand_if ();
    pps_out_if res_if ();

    pipelined_prime_sieve_filter uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cand  (cand_if),
        .res   (res_if)
    );

    cand_word_t             pending_words[$];
    prime_word_t            expected_primes[$];
    logic [VALUE_WIDTH-1:0] known_primes[MAX_PRIMES];
    int                     known_count = 0;
    int                     total_words = 0;
    int                     words_sent;
    int                     hold_left;
    bit                     hold_done;
    int                     error_count = 0;
    int                     cycle_count = 0;
    cand_word_t             drive_word;
    prime_word_t            seen_word;

    always #5 clk = ~clk;

    // Sieve prediction for one accepted candidate word
    function void screen_candidate(logic [VALUE_WIDTH-1:0] value, logic clear);
        prime_word_t w;
        if (clear)
            known_count = 0;
        if (value < 2)
            return;
        for (int i = 0; i < known_count; i++)
        begin
            if (value % known_primes[i] == 0)
                return;
        end
        w.prime      = value;
        w.not_stored = (known_count >= MAX_PRIMES);
        if (!w.not_stored)
        begin
            known_primes[known_count] = value;
            known_count++;
        end
        expected_primes.push_back(w);
    endfunction

    function automatic phase_t traffic_phase();
        int idx;
        idx = (total_words == 0) ? 0 : (words_sent * 5) / total_words;
        case (idx)
            0:       return PH_STEADY;
            1:       return PH_SEND_GAPS;
            2:       return PH_SINK_STALLS;
            3:       return PH_BOTH;
            default: return PH_DRAIN;
        endcase
    endfunction

    function automatic int send_gap_pct();
        case (traffic_phase())
            PH_SEND_GAPS: return 61;
            PH_BOTH:      return 26;
            default:      return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct();
        case (traffic_phase())
            PH_SINK_STALLS: return 61;
            PH_BOTH:        return 26;
            default:        return 0;
        endcase
    endfunction

    function void push_candidate(int value, bit clear);
        cand_word_t w;
        if (value < 0)
            value = 0;
        if (value > 65535)
            value = 65535;
        w.candidate = VALUE_WIDTH'(value);
        w.restart   = clear;
        pending_words.push_back(w);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_if.valid     <= 1'b0;
            cand_if.candidate <= '0;
            cand_if.restart   <= 1'b0;
            words_sent        <= 0;
        end
        else
        begin
            if (cand_if.valid && cand_if.ready)
            begin
                screen_candidate(cand_if.candidate, cand_if.restart);
                words_sent <= words_sent + 1;
            end
            if (!cand_if.valid || cand_if.ready)
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_gap_pct())
                begin
                    drive_word = pending_words.pop_front();
                    cand_if.valid     <= 1'b1;
                    cand_if.candidate <= drive_word.candidate;
                    cand_if.restart   <= drive_word.restart;
                end
                else
                    cand_if.valid <= 1'b0;
            end
        end
    end

    // Long output hold-off so the chain fills and back-pressures the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && total_words > 0 && words_sent >= total_words / 10)
        begin
            hold_left <= HOLD_OFF_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_primes.size() == 0)
                begin
                    $error("unexpected word: prime %0d not_stored %0b",
                           res_if.prime, res_if.not_stored);
                    error_count++;
                end
                else
                begin
                    seen_word = expected_primes.pop_front();
                    if (res_if.prime !== seen_word.prime)
                    begin
                        $error("prime: expected %0d, got %0d", seen_word.prime, res_if.prime);
                        error_count++;
                    end
                    if (res_if.not_stored !== seen_word.not_stored)
                    begin
                        $error("not_stored: expected %0b, got %0b",
                               seen_word.not_stored, res_if.not_stored);
                        error_count++;
                    end
                end
            end
            res_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct());
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int len;
        int v;
        int top;

        // directed words
        push_candidate(0, 1'b1);
        push_candidate(1, 1'b0);
        push_candidate(2, 1'b0);
        push_candidate(2, 1'b0);
        for (int i = 3; i <= 7; i++)
            push_candidate(i, 1'b0);
        push_candidate(9, 1'b1);
        push_candidate(3, 1'b0);
        push_candidate(27, 1'b0);
        push_candidate(65535, 1'b1);
        push_candidate(65534, 1'b0);
        push_candidate(0, 1'b0);
        push_candidate(1, 1'b1);
        push_candidate(65521, 1'b0);
        push_candidate(32768, 1'b0);
        push_candidate(16, 1'b0);
        push_candidate(21845, 1'b0);
        push_candidate(43690, 1'b0);

        // well-formed run long enough to fill the table, then large candidates
        top = 330 + $urandom_range(0, 90);
        push_candidate(2, 1'b1);
        for (int i = 3; i <= top; i++)
            push_candidate(i, 1'b0);
        v = $urandom_range(400, 60000);
        for (int i = 0; i < 20; i++)
        begin
            v = v + $urandom_range(1, 250);
            push_candidate(v, 1'b0);
        end

        while (pending_words.size() < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                len = $urandom_range(8, 60);
                push_candidate(2, 1'b1);
                for (int i = 3; i < len + 2; i++)
                    push_candidate(i, 1'b0);
            end
            else if (kind < 75)
            begin
                len = $urandom_range(5, 30);
                v = $urandom_range(2, 65535);
                for (int i = 0; i < len; i++)
                begin
                    push_candidate(v, 1'b0);
                    v = v + $urandom_range(1, 3);
                end
            end
            else if (kind < 88)
            begin
                len = $urandom_range(8, 40);
                v = 2;
                push_candidate(v, 1'b1);
                for (int i = 0; i < len; i++)
                begin
                    v = v + $urandom_range(0, 4);
                    if ($urandom_range(0, 5) == 0)
                        v = v - $urandom_range(1, 6);
                    push_candidate(v, 1'b0);
                end
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        v = $urandom_range(0, 1);
                    else
                        v = $urandom_range(0, 65535);
                    push_candidate(v, $urandom_range(0, 1));
                end
            end
        end
        total_words = pending_words.size();

        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (words_sent < total_words || expected_primes.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/pps_in_if.sv
rtl/core/pps_out_if.sv
rtl/core/pps_feed.sv
rtl/core/pps_cell.sv
rtl/core/pipelined_prime_sieve_filter.sv
dv/tb.sv
